FILE: rtl/shwsr_pkg.sv
// Package: phase encoding, status codes, register map and widths for the sensor reader.
`timescale 1ns / 1ps
package shwsr_pkg;

	// Number of bytes in one sensor frame (humidity 2, temperature 2, checksum 1)
	localparam int FRAME_BYTES = 5;
	localparam int BYTE_IDX_W  = 3;
	localparam int BIT_IDX_W   = 3;

	// Register widths
	localparam int GUARD_W  = 18;
	localparam int START_W  = 16;
	localparam int DELAY_W  = 10;
	localparam int EDGE_W   = 16;

	// APB map
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;

	// Register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_GUARD        = 3'd0;
	localparam logic [2:0] REG_START_LOW    = 3'd1;
	localparam logic [2:0] REG_FIRST_CHECK  = 3'd2;
	localparam logic [2:0] REG_SECOND_CHECK = 3'd3;
	localparam logic [2:0] REG_SETTLE       = 3'd4;
	localparam logic [2:0] REG_BIT_SAMPLE   = 3'd5;
	localparam logic [2:0] REG_EDGE_TIMEOUT = 3'd6;

	// Reset values of the registers
	localparam logic [GUARD_W-1:0] GUARD_RST        = 18'd100000;
	localparam logic [START_W-1:0] START_LOW_RST    = 16'd500;
	localparam logic [DELAY_W-1:0] FIRST_CHECK_RST  = 10'd40;
	localparam logic [DELAY_W-1:0] SECOND_CHECK_RST = 10'd80;
	localparam logic [DELAY_W-1:0] SETTLE_RST       = 10'd80;
	localparam logic [DELAY_W-1:0] BIT_SAMPLE_RST   = 10'd30;
	localparam logic [EDGE_W-1:0]  EDGE_TIMEOUT_RST = 16'd200;

	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_GUARD_PRE  = 4'd1,
		PH_START_LOW  = 4'd2,
		PH_CHECK_LOW  = 4'd3,
		PH_CHECK_HIGH = 4'd4,
		PH_SETTLE     = 4'd5,
		PH_WAIT_RISE  = 4'd6,
		PH_SAMPLE     = 4'd7,
		PH_WAIT_FALL  = 4'd8,
		PH_GUARD_POST = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_NO_LOW       = 3'd1,
		ST_NO_HIGH      = 3'd2,
		ST_EDGE_TIMEOUT = 3'd3,
		ST_BAD_CHECKSUM = 3'd4
	} status_t;

endpackage

FILE: rtl/shwsr_if.sv
// Interfaces: tick channel (start request, line sample) and result channel.
`timescale 1ns / 1ps
interface shwsr_tick_if;
	logic valid;
	logic ready;
	logic start_req;
	logic line_level;

	modport source (output valid, output start_req, output line_level, input ready);
	modport sink   (input valid, input start_req, input line_level, output ready);
endinterface

interface shwsr_res_if;
	logic        valid;
	logic        ready;
	logic        drive_enable;
	logic        drive_level;
	logic        busy_res;
	logic        done_res;
	logic [2:0]  status;
	logic [15:0] humidity_word;
	logic [15:0] temperature_word;
	logic [7:0]  received_checksum;

	modport source (output valid, output drive_enable, output drive_level, output busy_res,
		output done_res, output status, output humidity_word, output temperature_word,
		output received_checksum, input ready);
	modport sink   (input valid, input drive_enable, input drive_level, input busy_res,
		input done_res, input status, input humidity_word, input temperature_word,
		input received_checksum, output ready);
endinterface

FILE: rtl/single_wire_humidity_sensor_reader_unit.sv
// Top level: single-wire humidity/temperature sensor protocol sequencer.
//
// Usage
//  tick   : one word per timebase tick (normally 1 us) carrying start_req and the sampled
//           data line level. A start request is ignored while a reading is in progress.
//  result : one word per accepted tick, showing the state after that tick: line drive
//           (drive_enable / drive_level), busy, a one-word done pulse, the last status and
//           the stored frame bytes.
//  APB    : seven 32-bit timing registers at byte addresses 0x00..0x18; write only while idle.
// Output: a tick's result is registered and presented in the cycle after it is accepted.
// Throughput: one tick per cycle when not stalled; the sequencer state is updated in a
//   single pass from the accepted tick; the result register decouples the two channels.
// Stall: while a result is held and result.ready is low, tick.ready drops and no tick is
//   taken; nothing is lost or repeated. tick.ready = !result_valid || result.ready.
// Reset: arst_n clears the sequencer to idle, the frame bytes and status to zero, empties
//   the result register and loads the register reset values (guard 100000, start 500,
//   checks 40/80, settle 80, bit sample 30, edge timeout 200).
`timescale 1ns / 1ps
module single_wire_humidity_sensor_reader_unit
	import shwsr_pkg::*;
#(
	parameter int COUNTER_BITS = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	shwsr_tick_if.sink         tick,
	shwsr_res_if.source        result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	// Configuration registers
	logic [GUARD_W-1:0] guard_q;
	logic [START_W-1:0] start_low_q;
	logic [DELAY_W-1:0] first_check_q;
	logic [DELAY_W-1:0] second_check_q;
	logic [DELAY_W-1:0] settle_q;
	logic [DELAY_W-1:0] bit_sample_q;
	logic [EDGE_W-1:0]  edge_timeout_q;

	// Sequencer state
	phase_t                  phase_q, phase_n;
	logic [COUNTER_BITS-1:0] wait_count_q, wait_count_n;
	logic [BIT_IDX_W-1:0]    bit_index_q, bit_index_n;
	logic [BYTE_IDX_W-1:0]   byte_index_q, byte_index_n;
	logic [7:0]              shift_byte_q, shift_byte_n;
	logic [7:0]              frame_q [FRAME_BYTES];
	logic [7:0]              frame_n [FRAME_BYTES];
	status_t                 last_status_q, last_status_n;
	logic                    done_n;

	// Result register
	logic        res_valid_q;
	logic        drive_enable_q, drive_level_q, busy_q, done_q;
	logic [2:0]  status_q;
	logic [15:0] humidity_q, temperature_q;
	logic [7:0]  checksum_q;

	logic                    fire;
	logic [COUNTER_BITS-1:0] cnt_inc;
	logic [COUNTER_BITS-1:0] edge_limit;
	logic [7:0]              sum;
	logic [BYTE_IDX_W-1:0]   byte_inc;
	logic                    cfg_we;

	// Handshake
	assign tick.ready = !res_valid_q || result.ready;
	assign fire       = tick.valid && tick.ready;

	// APB register file
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guard_q        <= GUARD_RST;
			start_low_q    <= START_LOW_RST;
			first_check_q  <= FIRST_CHECK_RST;
			second_check_q <= SECOND_CHECK_RST;
			settle_q       <= SETTLE_RST;
			bit_sample_q   <= BIT_SAMPLE_RST;
			edge_timeout_q <= EDGE_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (paddr[4:2])
				REG_GUARD:        guard_q        <= pwdata[GUARD_W-1:0];
				REG_START_LOW:    start_low_q    <= pwdata[START_W-1:0];
				REG_FIRST_CHECK:  first_check_q  <= pwdata[DELAY_W-1:0];
				REG_SECOND_CHECK: second_check_q <= pwdata[DELAY_W-1:0];
				REG_SETTLE:       settle_q       <= pwdata[DELAY_W-1:0];
				REG_BIT_SAMPLE:   bit_sample_q   <= pwdata[DELAY_W-1:0];
				REG_EDGE_TIMEOUT: edge_timeout_q <= pwdata[EDGE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_GUARD:        prdata = PDATA_W'(guard_q);
			REG_START_LOW:    prdata = PDATA_W'(start_low_q);
			REG_FIRST_CHECK:  prdata = PDATA_W'(first_check_q);
			REG_SECOND_CHECK: prdata = PDATA_W'(second_check_q);
			REG_SETTLE:       prdata = PDATA_W'(settle_q);
			REG_BIT_SAMPLE:   prdata = PDATA_W'(bit_sample_q);
			REG_EDGE_TIMEOUT: prdata = PDATA_W'(edge_timeout_q);
			default:          prdata = '0;
		endcase
	end

	// Shared timing helpers
	assign cnt_inc    = wait_count_q + 1'b1;
	assign edge_limit = COUNTER_BITS'({1'b0, edge_timeout_q} + 17'd1);
	assign sum        = frame_q[0] + frame_q[1] + frame_q[2] + frame_q[3];
	assign byte_inc   = byte_index_q + 1'b1;

	// Next-state logic for one tick
	always_comb begin
		phase_n       = phase_q;
		wait_count_n  = wait_count_q;
		bit_index_n   = bit_index_q;
		byte_index_n  = byte_index_q;
		shift_byte_n  = shift_byte_q;
		frame_n       = frame_q;
		last_status_n = last_status_q;
		done_n        = 1'b0;

		case (phase_q)
			PH_IDLE: begin
				if (tick.start_req) begin
					phase_n      = PH_GUARD_PRE;
					wait_count_n = '0;
					bit_index_n  = '0;
					byte_index_n = '0;
					shift_byte_n = '0;
				end
			end
			PH_GUARD_PRE: begin
				wait_count_n = cnt_inc;
				if (cnt_inc >= COUNTER_BITS'(guard_q)) begin
					phase_n      = PH_START_LOW;
					wait_count_n = '0;
				end
			end
			PH_START_LOW: begin
				wait_count_n = cnt_inc;
				if (cnt_inc >= COUNTER_BITS'(start_low_q)) begin
					phase_n      = PH_CHECK_LOW;
					wait_count_n = '0;
				end
			end
			PH_CHECK_LOW: begin
				wait_count_n = cnt_inc;
				if (cnt_inc >= COUNTER_BITS'(first_check_q)) begin
					if (tick.line_level) begin
						done_n        = 1'b1;
						last_status_n = ST_NO_LOW;
					end else begin
						phase_n      = PH_CHECK_HIGH;
						wait_count_n = '0;
					end
				end
			end
			PH_CHECK_HIGH: begin
				wait_count_n = cnt_inc;
				if (cnt_inc >= COUNTER_BITS'(second_check_q)) begin
					if (!tick.line_level) begin
						done_n        = 1'b1;
						last_status_n = ST_NO_HIGH;
					end else begin
						phase_n      = PH_SETTLE;
						wait_count_n = '0;
					end
				end
			end
			PH_SETTLE: begin
				wait_count_n = cnt_inc;
				if (cnt_inc >= COUNTER_BITS'(settle_q)) begin
					phase_n      = PH_WAIT_RISE;
					wait_count_n = '0;
				end
			end
			PH_WAIT_RISE: begin
				if (tick.line_level) begin
					phase_n      = PH_SAMPLE;
					wait_count_n = '0;
				end else begin
					wait_count_n = cnt_inc;
					if (cnt_inc >= edge_limit) begin
						done_n        = 1'b1;
						last_status_n = ST_EDGE_TIMEOUT;
					end
				end
			end
			PH_SAMPLE: begin
				wait_count_n = cnt_inc;
				if (cnt_inc >= COUNTER_BITS'(bit_sample_q)) begin
					shift_byte_n = {shift_byte_q[6:0], tick.line_level};
					phase_n      = PH_WAIT_FALL;
					wait_count_n = '0;
				end
			end
			PH_WAIT_FALL: begin
				if (!tick.line_level) begin
					wait_count_n = '0;
					if (bit_index_q == BIT_IDX_W'(7)) begin
						// byte complete: store it and move on
						if (byte_index_q < BYTE_IDX_W'(FRAME_BYTES))
							frame_n[byte_index_q] = shift_byte_q;
						shift_byte_n = '0;
						bit_index_n  = '0;
						byte_index_n = byte_inc;
						if (byte_inc >= BYTE_IDX_W'(FRAME_BYTES))
							phase_n = PH_GUARD_POST;
						else
							phase_n = PH_WAIT_RISE;
					end else begin
						bit_index_n = bit_index_q + 1'b1;
						phase_n     = PH_WAIT_RISE;
					end
				end else begin
					wait_count_n = cnt_inc;
					if (cnt_inc >= edge_limit) begin
						done_n        = 1'b1;
						last_status_n = ST_EDGE_TIMEOUT;
					end
				end
			end
			PH_GUARD_POST: begin
				wait_count_n = cnt_inc;
				if (cnt_inc >= COUNTER_BITS'(guard_q)) begin
					done_n        = 1'b1;
					last_status_n = (sum == frame_q[4]) ? ST_OK : ST_BAD_CHECKSUM;
				end
			end
			default: begin
				phase_n      = PH_IDLE;
				wait_count_n = '0;
			end
		endcase

		// sequence end, normal or aborted
		if (done_n) begin
			phase_n      = PH_IDLE;
			wait_count_n = '0;
		end
	end

	// Sequencer state registers, advanced once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			wait_count_q  <= '0;
			bit_index_q   <= '0;
			byte_index_q  <= '0;
			shift_byte_q  <= '0;
			last_status_q <= ST_OK;
			for (int i = 0; i < FRAME_BYTES; i++)
				frame_q[i] <= '0;
		end else if (fire) begin
			phase_q       <= phase_n;
			wait_count_q  <= wait_count_n;
			bit_index_q   <= bit_index_n;
			byte_index_q  <= byte_index_n;
			shift_byte_q  <= shift_byte_n;
			last_status_q <= last_status_n;
			frame_q       <= frame_n;
		end
	end

	// Result word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (tick.ready)
			res_valid_q <= tick.valid;
	end

	// Result payload, loaded with the state after the tick
	always_ff @(posedge clk) begin
		if (fire) begin
			drive_enable_q <= (phase_n == PH_GUARD_PRE) || (phase_n == PH_START_LOW) ||
				(phase_n == PH_GUARD_POST);
			drive_level_q  <= (phase_n == PH_GUARD_PRE) || (phase_n == PH_GUARD_POST);
			busy_q         <= (phase_n != PH_IDLE);
			done_q         <= done_n;
			status_q       <= last_status_n;
			humidity_q     <= {frame_n[0], frame_n[1]};
			temperature_q  <= {frame_n[2], frame_n[3]};
			checksum_q     <= frame_n[4];
		end
	end

	assign result.valid             = res_valid_q;
	assign result.drive_enable      = drive_enable_q;
	assign result.drive_level       = drive_level_q;
	assign result.busy_res          = busy_q;
	assign result.done_res          = done_q;
	assign result.status            = status_q;
	assign result.humidity_word     = humidity_q;
	assign result.temperature_word  = temperature_q;
	assign result.received_checksum = checksum_q;

endmodule
